// File: src/nfps_pkg.sv
// Shared types and constants for the nearest foreground pixel search block.
// No dependencies.
package nfps_pkg;

  localparam int COORD_W  = 11;
  localparam int POS_W    = 13;
  localparam int RAD_W    = 7;
  localparam int OFF_W    = 8;
  localparam int SQ_W     = 14;
  localparam int DIST_W   = 15;
  localparam int PIX_X_W  = 9;
  localparam int PIX_Y_W  = 8;
  localparam int PIX_V_W  = 8;

  localparam logic [DIST_W-1:0]  DIST_LIMIT       = DIST_W'(10000);
  localparam logic [PIX_V_W-1:0] BACKGROUND_VALUE = PIX_V_W'(255);
  localparam logic [RAD_W-1:0]   RADIUS_RESET     = RAD_W'(50);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                     clear;
    logic                     cand;
    logic [DIST_W-1:0]        sq_dist;
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
  } nfps_cand_t;

endpackage

// File: src/nfps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nfps_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 76800
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/nfps_scan.sv
// Window scan sequencer: walks window positions one per cycle, issues map reads
// and candidate distances. Depends on nfps_pkg.
module nfps_scan #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 240
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [nfps_pkg::COORD_W-1:0]   query_x,
  input  logic signed [nfps_pkg::COORD_W-1:0]   query_y,
  input  logic [nfps_pkg::RAD_W-1:0]            radius,
  input  logic                                  out_free,
  output logic                                  busy,
  output logic                                  done,
  output logic                                  rd_en,
  output logic [$clog2(FRAME_WIDTH*FRAME_HEIGHT)-1:0] rd_addr,
  output nfps_pkg::nfps_cand_t                  cand
);
  import nfps_pkg::*;

  localparam int ADDR_W = $clog2(FRAME_WIDTH*FRAME_HEIGHT);
  localparam int BASE_W = POS_W + $clog2(FRAME_WIDTH + 1) + 2;
  localparam logic signed [BASE_W-1:0] W_BASE = BASE_W'(FRAME_WIDTH);
  localparam logic signed [POS_W-1:0]  W_POS  = POS_W'(FRAME_WIDTH);
  localparam logic signed [POS_W-1:0]  H_POS  = POS_W'(FRAME_HEIGHT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT0,
    S_INIT1,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t                    state_r;
  logic signed [POS_W-1:0]   qx_r, qy_r;
  logic [RAD_W-1:0]          r_r;
  logic [SQ_W-1:0]           rsq_r, dx_sq_r, dy_sq_r;
  logic signed [OFF_W-1:0]   dx_r, dy_r;
  logic signed [BASE_W-1:0]  row_base_r, col_addr_r, addr_r;
  nfps_cand_t                cand_r;

  logic signed [OFF_W-1:0]   r_pos, r_neg;
  logic signed [POS_W-1:0]   cur_x, cur_y, y_start, x_start;
  logic                      in_frame;
  logic signed [15:0]        dx_sq_inc, dy_sq_inc;

  assign r_pos   = $signed({1'b0, r_r});
  assign r_neg   = -r_pos;
  assign cur_x   = qx_r + POS_W'(dx_r);
  assign cur_y   = qy_r + POS_W'(dy_r);
  assign y_start = qy_r - POS_W'(r_pos);
  assign x_start = qx_r - POS_W'(r_pos);
  assign in_frame = (cur_x >= 0) && (cur_x < W_POS) && (cur_y >= 0) && (cur_y < H_POS);
  assign dx_sq_inc = $signed({2'b00, dx_sq_r}) + 16'($signed({dx_r, 1'b1}));
  assign dy_sq_inc = $signed({2'b00, dy_sq_r}) + 16'($signed({dy_r, 1'b1}));

  assign busy    = (state_r != S_IDLE);
  assign done    = (state_r == S_FIN) && out_free;
  assign rd_en   = (state_r == S_SCAN) && in_frame;
  assign rd_addr = addr_r[ADDR_W-1:0];
  assign cand    = cand_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      qx_r       <= '0;
      qy_r       <= '0;
      r_r        <= '0;
      rsq_r      <= '0;
      dx_sq_r    <= '0;
      dy_sq_r    <= '0;
      dx_r       <= '0;
      dy_r       <= '0;
      row_base_r <= '0;
      col_addr_r <= '0;
      addr_r     <= '0;
      cand_r     <= '0;
    end else begin
      cand_r.clear <= (state_r == S_INIT0);
      cand_r.cand  <= (state_r == S_SCAN) && in_frame;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            qx_r    <= POS_W'(query_x);
            qy_r    <= POS_W'(query_y);
            r_r     <= radius;
            state_r <= S_INIT0;
          end
        end
        S_INIT0: begin
          row_base_r   <= BASE_W'(y_start) * W_BASE;
          rsq_r        <= SQ_W'(r_r * r_r);
          cand_r.x     <= qx_r;
          cand_r.y     <= qy_r;
          state_r      <= S_INIT1;
        end
        S_INIT1: begin
          col_addr_r <= row_base_r + BASE_W'(x_start);
          addr_r     <= row_base_r + BASE_W'(x_start);
          dx_r       <= r_neg;
          dy_r       <= r_neg;
          dx_sq_r    <= rsq_r;
          dy_sq_r    <= rsq_r;
          state_r    <= S_SCAN;
        end
        S_SCAN: begin
          cand_r.sq_dist <= {1'b0, dx_sq_r} + {1'b0, dy_sq_r};
          cand_r.x       <= cur_x;
          cand_r.y       <= cur_y;
          if (dy_r == r_pos) begin
            if (dx_r == r_pos) begin
              state_r <= S_DRAIN;
            end else begin
              dx_r       <= dx_r + OFF_W'(1);
              dx_sq_r    <= dx_sq_inc[SQ_W-1:0];
              dy_r       <= r_neg;
              dy_sq_r    <= rsq_r;
              col_addr_r <= col_addr_r + BASE_W'(1);
              addr_r     <= col_addr_r + BASE_W'(1);
            end
          end else begin
            dy_r    <= dy_r + OFF_W'(1);
            dy_sq_r <= dy_sq_inc[SQ_W-1:0];
            addr_r  <= addr_r + W_BASE;
          end
        end
        S_DRAIN: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/nfps_pick.sv
// Best-candidate tracker: keeps the nearest foreground position seen so far.
// Depends on nfps_pkg.
module nfps_pick (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nfps_pkg::nfps_cand_t                cand,
  input  logic                                fg_bit,
  output logic signed [nfps_pkg::POS_W-1:0]   best_x,
  output logic signed [nfps_pkg::POS_W-1:0]   best_y,
  output logic                                best_hit
);
  import nfps_pkg::*;

  logic [DIST_W-1:0]        best_d_r;
  logic signed [POS_W-1:0]  best_x_r, best_y_r;
  logic                     hit_r;

  assign best_x   = best_x_r;
  assign best_y   = best_y_r;
  assign best_hit = hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_d_r <= DIST_LIMIT;
      best_x_r <= '0;
      best_y_r <= '0;
      hit_r    <= 1'b0;
    end else begin
      priority if (cand.clear) begin
        best_d_r <= DIST_LIMIT;
        best_x_r <= cand.x;
        best_y_r <= cand.y;
        hit_r    <= 1'b0;
      end else if (cand.cand && fg_bit && (cand.sq_dist < best_d_r)) begin
        best_d_r <= cand.sq_dist;
        best_x_r <= cand.x;
        best_y_r <= cand.y;
        hit_r    <= 1'b1;
      end
    end
  end

endmodule

// File: src/nearest_foreground_pixel_search.sv
// Nearest foreground pixel search. Write requests store one foreground bit of the
// frame map. A query request scans the (2r+1)^2 window around the query point, one
// position per cycle through the single read port of the frame map, then waits for
// the result register to drain if needed; the reset radius is 50. One query is in
// flight at a time; in_stall stays high until its result is loaded. The map has no
// reset. Depends on nfps_pkg, nfps_ram, nfps_scan and nfps_pick.
module nearest_foreground_pixel_search #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 240
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [nfps_pkg::RAD_W-1:0]           cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_opcode,
  input  logic [nfps_pkg::PIX_X_W-1:0]         in_pixel_x,
  input  logic [nfps_pkg::PIX_Y_W-1:0]         in_pixel_y,
  input  logic [nfps_pkg::PIX_V_W-1:0]         in_pixel_value,
  input  logic signed [nfps_pkg::COORD_W-1:0]  in_query_x,
  input  logic signed [nfps_pkg::COORD_W-1:0]  in_query_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [nfps_pkg::COORD_W-1:0]  out_found_x,
  output logic signed [nfps_pkg::COORD_W-1:0]  out_found_y,
  output logic                                 out_hit
);
  import nfps_pkg::*;

  localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [RAD_W-1:0]          radius_r;
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] found_x_r, found_y_r;
  logic                      hit_r;

  logic                      accept, start, wr_en, out_free, busy, done;
  logic                      rd_en, fg_bit;
  logic [ADDR_W-1:0]         wr_addr, rd_addr;
  nfps_cand_t                cand;
  logic signed [POS_W-1:0]   best_x, best_y;
  logic                      best_hit;

  assign accept   = in_valid && !in_stall;
  assign start    = accept && (in_opcode == OP_QUERY);
  assign wr_en    = accept && (in_opcode == OP_WRITE) &&
                    (32'(in_pixel_x) < FRAME_WIDTH) && (32'(in_pixel_y) < FRAME_HEIGHT);
  assign wr_addr  = ADDR_W'(32'(in_pixel_y) * FRAME_WIDTH + 32'(in_pixel_x));
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = busy;

  assign out_valid   = out_valid_r;
  assign out_found_x = found_x_r;
  assign out_found_y = found_y_r;
  assign out_hit     = hit_r;

  nfps_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_map (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_pixel_value != BACKGROUND_VALUE),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(fg_bit)
  );

  nfps_scan #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .query_x (in_query_x),
    .query_y (in_query_y),
    .radius  (radius_r),
    .out_free(out_free),
    .busy    (busy),
    .done    (done),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .cand    (cand)
  );

  nfps_pick u_pick (
    .clk     (clk),
    .rst_n   (rst_n),
    .cand    (cand),
    .fg_bit  (fg_bit),
    .best_x  (best_x),
    .best_y  (best_y),
    .best_hit(best_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= RADIUS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        radius_r <= cfg_wr_data;
      end
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      found_x_r <= best_x[COORD_W-1:0];
      found_y_r <= best_y[COORD_W-1:0];
      hit_r     <= best_hit;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !(out_valid_r && out_stall))
    else $error("result loaded over a pending result");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> in_stall)
    else $error("query accepted but block not busy");

  a_hit_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |->
      (!out_found_x[COORD_W-1] && (32'(out_found_x[COORD_W-2:0]) < FRAME_WIDTH) &&
       !out_found_y[COORD_W-1] && (32'(out_found_y[COORD_W-2:0]) < FRAME_HEIGHT)))
    else $error("hit reported outside the frame");

  a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> busy)
    else $error("map read while idle");

endmodule

// File: dv/nfps_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the nearest foreground pixel search block: keeps its own frame map and
// search radius, predicts every query result and compares it with the result channel.
// Depends on nfps_pkg.
module nfps_result_checker #(
  parameter int FRAME_W = 320,
  parameter int FRAME_H = 240
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [nfps_pkg::RAD_W-1:0]           cfg_wr_data,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic                                 in_opcode,
  input  logic [nfps_pkg::PIX_X_W-1:0]         in_pixel_x,
  input  logic [nfps_pkg::PIX_Y_W-1:0]         in_pixel_y,
  input  logic [nfps_pkg::PIX_V_W-1:0]         in_pixel_value,
  input  logic signed [nfps_pkg::COORD_W-1:0]  in_query_x,
  input  logic signed [nfps_pkg::COORD_W-1:0]  in_query_y,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [nfps_pkg::COORD_W-1:0]  out_found_x,
  input  logic signed [nfps_pkg::COORD_W-1:0]  out_found_y,
  input  logic                                 out_hit,
  output int                                   fail_count,
  output int                                   results_owed
);
  import nfps_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      hit;
  } found_t;

  bit     fg_map [0:FRAME_W*FRAME_H-1];
  found_t found_q [$];
  int     radius = int'(RADIUS_RESET);
  int     err_count = 0;

  initial fail_count = 0;
  initial results_owed = 0;

  // Scan columns outer, rows inner, both ascending; first strict improvement wins.
  function automatic found_t nearest_foreground(int qx, int qy, int r);
    found_t res;
    int     best;
    int     d;
    best    = int'(DIST_LIMIT);
    res.x   = COORD_W'(qx);
    res.y   = COORD_W'(qy);
    res.hit = 1'b0;
    for (int x = qx - r; x <= qx + r; x++) begin
      if (x < 0 || x >= FRAME_W) continue;
      for (int y = qy - r; y <= qy + r; y++) begin
        if (y < 0 || y >= FRAME_H) continue;
        if (!fg_map[y*FRAME_W + x]) continue;
        d = (x - qx) * (x - qx) + (y - qy) * (y - qy);
        if (d < best) begin
          best    = d;
          res.x   = COORD_W'(x);
          res.y   = COORD_W'(y);
          res.hit = 1'b1;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    found_t want;
    int     qx;
    int     qy;
    int     px;
    int     py;
    if (!rst_n) begin
      radius = int'(RADIUS_RESET);
    end else begin
      if (in_valid && !in_stall) begin
        if (in_opcode == OP_QUERY) begin
          qx = in_query_x;
          qy = in_query_y;
          found_q = {found_q, nearest_foreground(qx, qy, radius)};
        end else begin
          px = in_pixel_x;
          py = in_pixel_y;
          if (px < FRAME_W && py < FRAME_H) begin
            fg_map[py*FRAME_W + px] = (in_pixel_value != BACKGROUND_VALUE);
          end
        end
      end
      if (cfg_wr_en) begin
        radius = int'(cfg_wr_data);
      end
      if (out_valid && !out_stall) begin
        if (found_q.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d hit=%0b", $time,
                   out_found_x, out_found_y, out_hit);
          err_count++;
        end else begin
          want = found_q.pop_front();
          if (out_found_x !== want.x) begin
            $display("%0t: found_x expected %0d, got %0d", $time, want.x, out_found_x);
            err_count++;
          end
          if (out_found_y !== want.y) begin
            $display("%0t: found_y expected %0d, got %0d", $time, want.y, out_found_y);
            err_count++;
          end
          if (out_hit !== want.hit) begin
            $display("%0t: hit expected %0b, got %0b", $time, want.hit, out_hit);
            err_count++;
          end
        end
      end
    end
    results_owed <= found_q.size();
    fail_count   <= err_count;
  end

endmodule

// File: dv/tb_nearest_foreground_pixel_search.sv
`timescale 1ns / 100ps
// Top of the nearest foreground pixel search testbench: clock, reset, request stimulus,
// result-side stall pattern and verdict. Depends on nfps_pkg, nfps_result_checker and the block.
module tb_nearest_foreground_pixel_search;
  import nfps_pkg::*;

  localparam int FRAME_W     = 320;
  localparam int FRAME_H     = 240;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE      = 20;
  localparam int REGION      = 6;

  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       cfg_wr_en      = 1'b0;
  logic [RAD_W-1:0]           cfg_wr_data    = '0;
  logic                       in_valid       = 1'b0;
  logic                       in_stall;
  logic                       in_opcode      = OP_WRITE;
  logic [PIX_X_W-1:0]         in_pixel_x     = '0;
  logic [PIX_Y_W-1:0]         in_pixel_y     = '0;
  logic [PIX_V_W-1:0]         in_pixel_value = '0;
  logic signed [COORD_W-1:0]  in_query_x     = '0;
  logic signed [COORD_W-1:0]  in_query_y     = '0;
  logic                       out_valid;
  logic                       out_stall      = 1'b0;
  logic signed [COORD_W-1:0]  out_found_x;
  logic signed [COORD_W-1:0]  out_found_y;
  logic                       out_hit;

  int fail_count;
  int results_owed;
  int cycle_count     = 0;
  int stall_hold      = 0;
  int burst_left      = 0;
  bit sender_idles    = 1'b0;
  bit receiver_stalls = 1'b0;
  int write_count     = 0;
  int query_count     = 0;
  int radius_sets     = 0;

  nearest_foreground_pixel_search #(
    .FRAME_WIDTH  (FRAME_W),
    .FRAME_HEIGHT (FRAME_H)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_pixel_value (in_pixel_value),
    .in_query_x     (in_query_x),
    .in_query_y     (in_query_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found_x    (out_found_x),
    .out_found_y    (out_found_y),
    .out_hit        (out_hit)
  );

  nfps_result_checker #(
    .FRAME_W (FRAME_W),
    .FRAME_H (FRAME_H)
  ) result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .in_pixel_value (in_pixel_value),
    .in_query_x     (in_query_x),
    .in_query_y     (in_query_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found_x    (out_found_x),
    .out_found_y    (out_found_y),
    .out_hit        (out_hit),
    .fail_count     (fail_count),
    .results_owed   (results_owed)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results owed", cycle_count, results_owed);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Hold stall for a random stretch, then release.
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_hold <= $urandom_range(0, 24);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_request(input logic op, input int px, input int py, input int pv,
                              input int qx, input int qy);
    if (sender_idles && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_pixel_x     <= PIX_X_W'(px);
    in_pixel_y     <= PIX_Y_W'(py);
    in_pixel_value <= PIX_V_W'(pv);
    in_query_x     <= COORD_W'(qx);
    in_query_y     <= COORD_W'(qy);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (op == OP_QUERY) query_count++;
    else write_count++;
  endtask

  task automatic write_pixel(input int px, input int py, input int pv);
    send_request(OP_WRITE, px, py, pv, $urandom_range(0, 2047), $urandom_range(0, 2047));
  endtask

  task automatic run_query(input int qx, input int qy);
    send_request(OP_QUERY, $urandom_range(0, 511), $urandom_range(0, 255),
                 $urandom_range(0, 255), qx, qy);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic set_radius(input int r);
    wait_results();
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= RAD_W'(r);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    radius_sets++;
  endtask

  initial begin
    int sel;
    int px;
    int py;
    int pv;
    int qx;
    int qy;
    int r;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // clear the corner region; every query window stays inside written pixels
    for (int y = 0; y < REGION; y++) begin
      for (int x = 0; x < REGION; x++) begin
        write_pixel(x, y, BACKGROUND_VALUE);
      end
    end

    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;

    // reset radius
    run_query(-50, -50);
    write_pixel(0, 0, 0);
    write_pixel(FRAME_W - 1, FRAME_H - 1, 254);
    write_pixel(FRAME_W, 5, 0);
    write_pixel(5, FRAME_H, 0);
    write_pixel(511, 255, 0);
    write_pixel(20, 20, 1);
    write_pixel(20, 20, BACKGROUND_VALUE);
    run_query(-50, -50);
    run_query(-45, -45);
    run_query(-1024, -1024);
    run_query(1023, 1023);

    set_radius(0);
    run_query(0, 0);
    run_query(20, 20);
    run_query(FRAME_W - 1, FRAME_H - 1);
    run_query(FRAME_W, FRAME_H);
    run_query(3, 3);

    // equal distances around (2,2): lowest column, then lowest row wins
    write_pixel(0, 2, 128);
    write_pixel(4, 2, 64);
    write_pixel(2, 0, 3);
    write_pixel(2, 4, 9);
    set_radius(2);
    run_query(2, 2);
    run_query(-3, -3);

    // distance limit: squared distance 10082 is rejected, 9800 accepted
    set_radius(71);
    run_query(-71, -71);
    set_radius(70);
    run_query(-70, -70);
    set_radius(127);
    run_query(-127, -127);
    run_query(1023, -1024);

    set_radius(1);
    run_query(1, 1);

    for (int phase = 0; phase < 4; phase++) begin
      sender_idles    = (phase != 2);
      receiver_stalls = (phase != 2);
      r = (phase == 0) ? 0 : int'($urandom_range(0, REGION - 1));
      set_radius(r);
      repeat ($urandom_range(8, 10)) begin
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
          sel = $urandom_range(0, 99);
          if (sel < 60) begin
            px = $urandom_range(0, REGION - 1);
            py = $urandom_range(0, REGION - 1);
          end else if (sel < 80) begin
            px = $urandom_range(0, FRAME_W - 1);
            py = $urandom_range(0, FRAME_H - 1);
          end else begin
            px = $urandom_range(0, 511);
            py = $urandom_range(0, 255);
          end
          pv = $urandom_range(0, 1) ? int'(BACKGROUND_VALUE) : $urandom_range(0, 255);
          write_pixel(px, py, pv);
        end else begin
          sel = $urandom_range(0, 99);
          if (sel < 70) begin
            qx = int'($urandom_range(0, REGION + 2)) - r - 3;
            qy = int'($urandom_range(0, REGION + 2)) - r - 3;
          end else if (sel < 85) begin
            qx = FRAME_W + r + int'($urandom_range(0, 600));
            qy = $urandom_range(0, 2047);
          end else begin
            qx = -1024 + int'($urandom_range(0, 896));
            qy = $urandom_range(0, 2047);
          end
          run_query(qx, qy);
        end
        if ($urandom_range(0, 7) == 0) wait_results();
      end
    end

    wait_results();
    repeat (SETTLE) @(posedge clk);
    $display("Run covered %0d pixel writes and %0d queries, each window inside written pixels,",
             write_count, query_count);
    $display("over %0d search radius settings including 0 and 127.", radius_sets);
    if (fail_count == 0 && results_owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, results_owed);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
src/nfps_pkg.sv
src/nfps_ram.sv
src/nfps_scan.sv
src/nfps_pick.sv
src/nearest_foreground_pixel_search.sv
dv/nfps_result_checker.sv
dv/tb_nearest_foreground_pixel_search.sv
